// ===== rtl/arpc_pkg.sv =====
// Shared types, codes and constants of the ARP cache resolver.
`timescale 1ns / 1ps
`default_nettype none

package arpc_pkg;

  localparam int unsigned ENTRIES_DEF    = 16;
  localparam int unsigned WAIT_DEPTH_DEF = 4;
  localparam int unsigned TAG_BITS_DEF   = 8;

  localparam logic [31:0] BCAST_IP   = 32'hffff_ffff;
  localparam logic [47:0] BCAST_MAC  = 48'hffff_ffff_ffff;
  localparam logic [15:0] HW_ETHER   = 16'h0001;
  localparam logic [15:0] PROTO_IPV4 = 16'h0800;
  localparam logic [15:0] OP_REQUEST = 16'h0001;
  localparam logic [15:0] OP_REPLY   = 16'h0002;

  localparam logic [31:0] OWN_IP_RST       = 32'd0;
  localparam logic [47:0] OWN_MAC_RST      = 48'd0;
  localparam logic [15:0] LIFETIME_RST     = 16'd30000;
  localparam logic [15:0] REQ_TIMEOUT_RST  = 16'd1000;
  localparam logic [3:0]  MAX_RETRIES_RST  = 4'd3;
  localparam logic [15:0] STALE_PERIOD_RST = 16'd10000;

  typedef enum logic [1:0] {
    REQ_PACKET  = 2'd0,
    REQ_RESOLVE = 2'd1,
    REQ_TICK    = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    RK_FOUND   = 3'd0,
    RK_QUEUED  = 3'd1,
    RK_REQUEST = 3'd2,
    RK_REPLY   = 3'd3,
    RK_RELEASE = 3'd4,
    RK_UNREACH = 3'd5,
    RK_DROPPED = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    CFG_OWN_IP       = 3'd0,
    CFG_OWN_MAC      = 3'd1,
    CFG_LIFETIME     = 3'd2,
    CFG_REQ_TIMEOUT  = 3'd3,
    CFG_MAX_RETRIES  = 3'd4,
    CFG_STALE_PERIOD = 3'd5
  } cfg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_FIND_RD,
    S_FIND_CHK,
    S_POST_FIND,
    S_ENQ,
    S_EMIT1,
    S_REL_RD,
    S_REL_EMIT,
    S_TICK_RD,
    S_TICK_CHK,
    S_TICK_NEXT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic [31:0] stamp;
    logic [3:0]  retries;
    logic [15:0] rtimer;
  } slot_rec_t;

  typedef struct packed {
    kind_e       kind;
    logic [47:0] mac;
    logic [31:0] ip;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/arpc_ram.sv =====
// Single write port, single read port synchronous RAM, registered read.
`timescale 1ns / 1ps
`default_nettype none

module arpc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                      wdata_i,
  input  wire logic                                  re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/arpc_out_buf.sv =====
// Result hold stage and output register; marks the final word of each item.
`timescale 1ns / 1ps
`default_nettype none

module arpc_out_buf
  import arpc_pkg::*;
#(
  parameter int unsigned TAG_BITS = TAG_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                emit_i,
  input  wire res_t                emit_res_i,
  input  wire logic [TAG_BITS-1:0] emit_tag_i,
  output logic                     emit_ok_o,
  input  wire logic                flush_i,
  output logic                     flush_ok_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [2:0]               result_kind_o,
  output logic [47:0]              mac_addr_o,
  output logic [31:0]              ip_addr_o,
  output logic [TAG_BITS-1:0]      tag_o,
  output logic                     last_o
);

  logic                hold_v_q, hold_v_d;
  res_t                hold_res_q;
  logic [TAG_BITS-1:0] hold_tag_q;
  logic                out_v_q, out_v_d;
  res_t                out_res_q;
  logic [TAG_BITS-1:0] out_tag_q;
  logic                out_last_q;
  logic                out_free, load, load_last, take;

  assign out_free   = !out_v_q || out_ready_i;
  assign emit_ok_o  = !hold_v_q || out_free;
  assign flush_ok_o = emit_ok_o;

  always_comb begin
    take      = 1'b0;
    load      = 1'b0;
    load_last = 1'b0;
    hold_v_d  = hold_v_q;
    if (emit_i && emit_ok_o) begin
      take     = 1'b1;
      load     = hold_v_q;
      hold_v_d = 1'b1;
    end else if (flush_i && flush_ok_o) begin
      load      = hold_v_q;
      load_last = 1'b1;
      hold_v_d  = 1'b0;
    end
    if (load) begin
      out_v_d = 1'b1;
    end else if (out_ready_i) begin
      out_v_d = 1'b0;
    end else begin
      out_v_d = out_v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      hold_v_q <= hold_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      hold_res_q <= emit_res_i;
      hold_tag_q <= emit_tag_i;
    end
    if (load) begin
      out_res_q  <= hold_res_q;
      out_tag_q  <= hold_tag_q;
      out_last_q <= load_last;
    end
  end

  assign out_valid_o   = out_v_q;
  assign result_kind_o = out_res_q.kind;
  assign mac_addr_o    = out_res_q.mac;
  assign ip_addr_o     = out_res_q.ip;
  assign tag_o         = out_tag_q;
  assign last_o        = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/arp_cache_resolver.sv =====
// ARP cache resolver top level: sequencer, entry flags, slot and tag RAMs.
//
//   port group   dir  handshake                 word
//   in_*         in   in_valid_i / in_ready_o   received packet, resolve or tick
//   out_*        out  out_valid_o / out_ready_i one result, last_o on final
//   cfg_*        in   cfg_valid_i / cfg_ready_o register index and data
//
// One item at a time. Entry lookups read and then compare each used entry of
// the slot RAM in turn, and a packet may then release the waiting tags. A tick
// walks every entry, checks pending and (on a sweep) resolved ones, emits
// request and unreachable words and removes timed-out or stale entries.
// Reset clears entry flags, clocks and config; no clearing pass.
// Output back-pressure stalls the sequencer at the next emitted word.
`timescale 1ns / 1ps
`default_nettype none

module arp_cache_resolver
  import arpc_pkg::*;
#(
  parameter int unsigned ENTRIES    = ENTRIES_DEF,
  parameter int unsigned WAIT_DEPTH = WAIT_DEPTH_DEF,
  parameter int unsigned TAG_BITS   = TAG_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [1:0]          req_type_i,
  input  wire logic [15:0]         hw_type_i,
  input  wire logic [15:0]         proto_type_i,
  input  wire logic [15:0]         opcode_i,
  input  wire logic [47:0]         sender_mac_i,
  input  wire logic [31:0]         sender_ip_i,
  input  wire logic [31:0]         target_ip_i,
  input  wire logic [TAG_BITS-1:0] packet_tag_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [2:0]               result_kind_o,
  output logic [47:0]              mac_addr_o,
  output logic [31:0]              ip_addr_o,
  output logic [TAG_BITS-1:0]      tag_o,
  output logic                     last_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [2:0]          cfg_index_i,
  input  wire logic [47:0]         cfg_data_i
);

  localparam int unsigned IW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW  = $clog2(WAIT_DEPTH + 1);
  localparam int unsigned TD  = ENTRIES * WAIT_DEPTH;
  localparam int unsigned TAW = (TD > 1) ? $clog2(TD) : 1;

  // configuration
  logic [31:0] own_ip_q;
  logic [47:0] own_mac_q;
  logic [15:0] lifetime_q, timeout_q, period_q;
  logic [3:0]  max_retries_q;

  // entry flags
  logic [ENTRIES-1:0] used_q, res_q, pend_q;
  logic [CW-1:0]      wcnt_q [ENTRIES];

  // item and sequencer registers
  state_e              state_q, state_d;
  req_e                req_q;
  logic                hw_ok_q;
  logic [15:0]         op_q;
  logic [47:0]         smac_q;
  logic [31:0]         sip_q, tip_q;
  logic [TAG_BITS-1:0] tag_q;
  logic [IW-1:0]       idx_q;
  logic [CW-1:0]       k_q;
  logic                found_q, req_after_q;
  slot_rec_t           rec_q;
  kind_e               rk_q;
  logic [47:0]         rmac_q;
  logic [31:0]         now_q;
  logic [15:0]         sweep_q;
  logic                sweep_hit_q;

  // RAM ports
  logic                slot_we, slot_re;
  logic [IW-1:0]       slot_waddr, slot_raddr;
  slot_rec_t           slot_wdata, slot_rd;
  logic                tag_we, tag_re;
  logic [TAW-1:0]      tag_addr;
  logic [TAG_BITS-1:0] tag_rd;

  // result stage
  logic                emit_v, emit_ok, flush, flush_ok;
  res_t                emit_res;
  logic [TAG_BITS-1:0] emit_tag;

  // helpers
  logic [31:0]   key_ip, age, rd_age;
  logic          is_req, is_rep, tip_own, sip_nz;
  logic          learn_go, learn_force, reply_go;
  logic          res_own, res_bc, res_zero;
  logic          cur_used, cur_res, cur_pend, idx_last, fresh, rd_match;
  logic [CW-1:0] wcnt_cur, k_sel;
  logic          wq_full, rel_more;
  logic [15:0]   rt_inc;
  logic [3:0]    ret_inc;
  logic          free_v;
  logic [IW-1:0] free_idx, post_slot;
  logic [15:0]   sweep_inc;
  logic          create_go;

  assign key_ip      = (req_q == REQ_RESOLVE) ? tip_q : sip_q;
  assign is_req      = op_q == OP_REQUEST;
  assign is_rep      = op_q == OP_REPLY;
  assign tip_own     = tip_q == own_ip_q;
  assign sip_nz      = sip_q != 32'd0;
  assign learn_go    = hw_ok_q && sip_nz && (is_req || is_rep);
  assign learn_force = is_rep || tip_own;
  assign reply_go    = hw_ok_q && is_req && tip_own;
  assign res_own     = tip_q == own_ip_q;
  assign res_bc      = tip_q == BCAST_IP;
  assign res_zero    = tip_q == 32'd0;
  assign cur_used    = used_q[idx_q];
  assign cur_res     = res_q[idx_q];
  assign cur_pend    = pend_q[idx_q];
  assign wcnt_cur    = wcnt_q[idx_q];
  assign idx_last    = idx_q == IW'(ENTRIES - 1);
  assign age         = now_q - rec_q.stamp;
  assign rd_age      = now_q - slot_rd.stamp;
  assign fresh       = found_q && (age < {16'd0, lifetime_q});
  assign rd_match    = slot_rd.ip == key_ip;
  assign wq_full     = wcnt_cur == CW'(WAIT_DEPTH);
  assign rel_more    = k_q < wcnt_cur;
  assign rt_inc      = slot_rd.rtimer + 16'd1;
  assign ret_inc     = slot_rd.retries + 4'd1;
  assign post_slot   = found_q ? idx_q : free_idx;
  assign sweep_inc   = sweep_q + 16'd1;
  assign k_sel       = (state_q == S_ENQ) ? wcnt_cur : k_q;
  assign tag_addr    = TAW'(idx_q) * TAW'(WAIT_DEPTH) + TAW'(k_sel);
  assign create_go   = !(fresh && (cur_res || cur_pend)) && (found_q || free_v);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    free_v   = 1'b0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_v   = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        case (req_q)
          REQ_PACKET: begin
            if (learn_go) state_d = S_FIND_RD;
            else if (reply_go) state_d = S_EMIT1;
            else state_d = S_DONE;
          end
          REQ_RESOLVE: begin
            if (res_own || res_bc || res_zero) state_d = S_EMIT1;
            else state_d = S_FIND_RD;
          end
          REQ_TICK: state_d = S_TICK_RD;
          default:  state_d = S_DONE;
        endcase
      end
      S_FIND_RD: begin
        if (cur_used) state_d = S_FIND_CHK;
        else if (idx_last) state_d = S_POST_FIND;
      end
      S_FIND_CHK: begin
        if (rd_match || idx_last) state_d = S_POST_FIND;
        else state_d = S_FIND_RD;
      end
      S_POST_FIND: begin
        if (req_q == REQ_RESOLVE) begin
          if (fresh && cur_res) state_d = S_EMIT1;
          else if (fresh && cur_pend) state_d = S_ENQ;
          else if (!found_q && !free_v) state_d = S_EMIT1;
          else state_d = S_ENQ;
        end else begin
          if (found_q && learn_force && cur_pend) state_d = S_REL_RD;
          else if (reply_go) state_d = S_EMIT1;
          else state_d = S_DONE;
        end
      end
      S_ENQ: begin
        if (emit_ok) state_d = req_after_q ? S_EMIT1 : S_DONE;
      end
      S_EMIT1: begin
        if (emit_ok) state_d = (req_q == REQ_TICK) ? S_TICK_NEXT : S_DONE;
      end
      S_REL_RD: begin
        if (rel_more) state_d = S_REL_EMIT;
        else if (req_q == REQ_TICK) state_d = S_TICK_NEXT;
        else if (reply_go) state_d = S_EMIT1;
        else state_d = S_DONE;
      end
      S_REL_EMIT: begin
        if (emit_ok) state_d = S_REL_RD;
      end
      S_TICK_RD: begin
        if (cur_used && (cur_pend || (sweep_hit_q && cur_res))) state_d = S_TICK_CHK;
        else state_d = S_TICK_NEXT;
      end
      S_TICK_CHK: begin
        if (cur_pend && (rt_inc >= timeout_q)) begin
          state_d = (ret_inc < max_retries_q) ? S_EMIT1 : S_REL_RD;
        end else begin
          state_d = S_TICK_NEXT;
        end
      end
      S_TICK_NEXT: begin
        state_d = idx_last ? S_DONE : S_TICK_RD;
      end
      S_DONE: begin
        if (flush_ok) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    slot_we    = 1'b0;
    slot_re    = 1'b0;
    slot_waddr = idx_q;
    slot_raddr = idx_q;
    slot_wdata = slot_rd;
    tag_we     = 1'b0;
    tag_re     = 1'b0;
    emit_v     = 1'b0;
    emit_res   = '{kind: rk_q, mac: rmac_q, ip: key_ip};
    emit_tag   = tag_q;
    flush      = 1'b0;
    unique case (state_q)
      S_IDLE:    in_ready_o = 1'b1;
      S_FIND_RD: slot_re = cur_used;
      S_TICK_RD: slot_re = cur_used && (cur_pend || (sweep_hit_q && cur_res));
      S_POST_FIND: begin
        slot_waddr = post_slot;
        if (req_q == REQ_RESOLVE) begin
          slot_we    = create_go;
          slot_wdata = '{ip: key_ip, mac: found_q ? rec_q.mac : 48'd0, stamp: now_q,
                         retries: 4'd0, rtimer: 16'd0};
        end else if (found_q) begin
          slot_we    = learn_force;
          slot_wdata = '{ip: rec_q.ip, mac: smac_q, stamp: now_q,
                         retries: rec_q.retries, rtimer: rec_q.rtimer};
        end else begin
          slot_we    = free_v;
          slot_wdata = '{ip: sip_q, mac: smac_q, stamp: now_q,
                         retries: 4'd0, rtimer: 16'd0};
        end
      end
      S_ENQ: begin
        emit_v   = 1'b1;
        emit_res = '{kind: wq_full ? RK_DROPPED : RK_QUEUED, mac: 48'd0, ip: key_ip};
        tag_we   = emit_ok && !wq_full;
      end
      S_EMIT1: begin
        emit_v   = 1'b1;
        emit_res = '{kind: rk_q, mac: rmac_q,
                     ip: (req_q == REQ_TICK) ? rec_q.ip : key_ip};
        if (rk_q == RK_REPLY || rk_q == RK_REQUEST) emit_tag = '0;
      end
      S_REL_RD: tag_re = rel_more;
      S_REL_EMIT: begin
        emit_v   = 1'b1;
        emit_res = '{kind: (req_q == REQ_TICK) ? RK_UNREACH : RK_RELEASE,
                     mac: (req_q == REQ_TICK) ? 48'd0 : smac_q, ip: rec_q.ip};
        emit_tag = tag_rd;
      end
      S_TICK_CHK: begin
        slot_we = cur_pend;
        if (rt_inc < timeout_q) begin
          slot_wdata.rtimer = rt_inc;
        end else begin
          slot_wdata.rtimer  = 16'd0;
          slot_wdata.retries = ret_inc;
        end
      end
      S_DONE: flush = 1'b1;
      default: ;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q      <= OWN_IP_RST;
      own_mac_q     <= OWN_MAC_RST;
      lifetime_q    <= LIFETIME_RST;
      timeout_q     <= REQ_TIMEOUT_RST;
      max_retries_q <= MAX_RETRIES_RST;
      period_q      <= STALE_PERIOD_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_OWN_IP:       own_ip_q      <= cfg_data_i[31:0];
        CFG_OWN_MAC:      own_mac_q     <= cfg_data_i;
        CFG_LIFETIME:     lifetime_q    <= cfg_data_i[15:0];
        CFG_REQ_TIMEOUT:  timeout_q     <= cfg_data_i[15:0];
        CFG_MAX_RETRIES:  max_retries_q <= cfg_data_i[3:0];
        CFG_STALE_PERIOD: period_q      <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // sequencer, flags and item registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      res_q       <= '0;
      pend_q      <= '0;
      for (int i = 0; i < ENTRIES; i++) wcnt_q[i] <= '0;
      now_q       <= '0;
      sweep_q     <= '0;
      sweep_hit_q <= 1'b0;
      req_q       <= REQ_PACKET;
      hw_ok_q     <= 1'b0;
      op_q        <= '0;
      smac_q      <= '0;
      sip_q       <= '0;
      tip_q       <= '0;
      tag_q       <= '0;
      idx_q       <= '0;
      k_q         <= '0;
      found_q     <= 1'b0;
      req_after_q <= 1'b0;
      rec_q       <= '0;
      rk_q        <= RK_FOUND;
      rmac_q      <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            req_q       <= req_e'(req_type_i);
            hw_ok_q     <= (hw_type_i == HW_ETHER) && (proto_type_i == PROTO_IPV4);
            op_q        <= opcode_i;
            smac_q      <= sender_mac_i;
            sip_q       <= sender_ip_i;
            tip_q       <= target_ip_i;
            tag_q       <= packet_tag_i;
            idx_q       <= '0;
            k_q         <= '0;
            found_q     <= 1'b0;
            req_after_q <= 1'b0;
          end
        end
        S_DECODE: begin
          if (req_q == REQ_PACKET) begin
            rk_q   <= RK_REPLY;
            rmac_q <= smac_q;
          end else if (req_q == REQ_RESOLVE) begin
            if (res_own) begin
              rk_q   <= RK_FOUND;
              rmac_q <= own_mac_q;
            end else if (res_bc) begin
              rk_q   <= RK_FOUND;
              rmac_q <= BCAST_MAC;
            end else begin
              rk_q   <= RK_DROPPED;
              rmac_q <= '0;
            end
          end else if (req_q == REQ_TICK) begin
            now_q <= now_q + 32'd1;
            if (sweep_inc >= period_q) begin
              sweep_q     <= '0;
              sweep_hit_q <= 1'b1;
            end else begin
              sweep_q     <= sweep_inc;
              sweep_hit_q <= 1'b0;
            end
          end
        end
        S_FIND_RD: begin
          if (!cur_used && !idx_last) idx_q <= idx_q + 1'b1;
        end
        S_FIND_CHK: begin
          if (rd_match) begin
            found_q <= 1'b1;
            rec_q   <= slot_rd;
          end else if (!idx_last) begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_POST_FIND: begin
          k_q <= '0;
          if (req_q == REQ_RESOLVE) begin
            if (fresh && cur_res) begin
              rk_q   <= RK_FOUND;
              rmac_q <= rec_q.mac;
            end else if (fresh && cur_pend) begin
              req_after_q <= 1'b0;
            end else if (!found_q && !free_v) begin
              rk_q   <= RK_DROPPED;
              rmac_q <= '0;
            end else begin
              idx_q             <= post_slot;
              used_q[post_slot] <= 1'b1;
              res_q[post_slot]  <= 1'b0;
              pend_q[post_slot] <= 1'b1;
              if (!(found_q && pend_q[post_slot])) wcnt_q[post_slot] <= '0;
              req_after_q       <= 1'b1;
            end
          end else if (found_q) begin
            if (learn_force) res_q[idx_q] <= 1'b1;
          end else if (free_v) begin
            used_q[free_idx] <= 1'b1;
            res_q[free_idx]  <= 1'b1;
            pend_q[free_idx] <= 1'b0;
            wcnt_q[free_idx] <= '0;
          end
        end
        S_ENQ: begin
          if (emit_ok) begin
            if (!wq_full) wcnt_q[idx_q] <= wcnt_cur + 1'b1;
            rk_q   <= RK_REQUEST;
            rmac_q <= '0;
          end
        end
        S_REL_RD: begin
          if (!rel_more) begin
            if (req_q == REQ_TICK) begin
              used_q[idx_q] <= 1'b0;
              res_q[idx_q]  <= 1'b0;
            end
            pend_q[idx_q] <= 1'b0;
            wcnt_q[idx_q] <= '0;
          end
        end
        S_REL_EMIT: begin
          if (emit_ok) k_q <= k_q + 1'b1;
        end
        S_TICK_CHK: begin
          rec_q <= slot_rd;
          k_q   <= '0;
          if (cur_pend) begin
            rk_q   <= RK_REQUEST;
            rmac_q <= '0;
          end else if (rd_age > {16'd0, lifetime_q}) begin
            used_q[idx_q] <= 1'b0;
            res_q[idx_q]  <= 1'b0;
            pend_q[idx_q] <= 1'b0;
            wcnt_q[idx_q] <= '0;
          end
        end
        S_TICK_NEXT: begin
          if (!idx_last) idx_q <= idx_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  arpc_ram #(
    .WIDTH ($bits(slot_rec_t)),
    .DEPTH (ENTRIES)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .re_i    (slot_re),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rd)
  );

  arpc_ram #(
    .WIDTH (TAG_BITS),
    .DEPTH (TD)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (tag_addr),
    .wdata_i (tag_q),
    .re_i    (tag_re),
    .raddr_i (tag_addr),
    .rdata_o (tag_rd)
  );

  arpc_out_buf #(
    .TAG_BITS (TAG_BITS)
  ) u_out_buf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .emit_i        (emit_v),
    .emit_res_i    (emit_res),
    .emit_tag_i    (emit_tag),
    .emit_ok_o     (emit_ok),
    .flush_i       (flush),
    .flush_ok_o    (flush_ok),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_kind_o (result_kind_o),
    .mac_addr_o    (mac_addr_o),
    .ip_addr_o     (ip_addr_o),
    .tag_o         (tag_o),
    .last_o        (last_o)
  );

endmodule

`default_nettype wire

// ===== verif/arp_cache_resolver_tb.sv =====
// Testbench for the ARP cache resolver: scoreboard predictor plus random handshake stimulus.
`timescale 1ns / 1ps

module arp_cache_resolver_tb;
  import arpc_pkg::*;

  typedef struct {
    logic [1:0]  rtype;
    logic [15:0] hw;
    logic [15:0] proto;
    logic [15:0] op;
    logic [47:0] smac;
    logic [31:0] sip;
    logic [31:0] tip;
    logic [7:0]  ptag;
  } arp_word_t;

  typedef struct {
    kind_e       kind;
    logic [47:0] mac;
    logic [31:0] ip;
    logic [7:0]  tag;
    bit          fin;
  } arp_res_t;

  class arp_scoreboard;
    logic [31:0] my_ip;
    logic [47:0] my_mac;
    logic [15:0] lifetime, rq_timeout, sweep_period;
    logic [3:0]  retry_max;
    bit          used[16], resolved[16], pending[16];
    logic [31:0] ent_ip[16], stamp[16];
    logic [47:0] ent_mac[16];
    logic [3:0]  retries[16];
    logic [15:0] rtimer[16];
    logic [7:0]  wtag[16][4];
    int          wcnt[16];
    logic [31:0] now;
    logic [15:0] sweep;
    arp_res_t    step_q[$];
    arp_res_t    due_q[$];
    int          errors;
    int          n_words, n_results;

    function new();
      my_ip = OWN_IP_RST; my_mac = OWN_MAC_RST; lifetime = LIFETIME_RST;
      rq_timeout = REQ_TIMEOUT_RST; retry_max = MAX_RETRIES_RST;
      sweep_period = STALE_PERIOD_RST; now = 0; sweep = 0; errors = 0;
      n_words = 0; n_results = 0;
      for (int i = 0; i < 16; i++) begin
        used[i] = 0; resolved[i] = 0; pending[i] = 0; wcnt[i] = 0;
      end
    endfunction

    function void set_reg(cfg_e idx, logic [47:0] d);
      case (idx)
        CFG_OWN_IP:       my_ip = d[31:0];
        CFG_OWN_MAC:      my_mac = d;
        CFG_LIFETIME:     lifetime = d[15:0];
        CFG_REQ_TIMEOUT:  rq_timeout = d[15:0];
        CFG_MAX_RETRIES:  retry_max = d[3:0];
        CFG_STALE_PERIOD: sweep_period = d[15:0];
        default: ;
      endcase
    endfunction

    function void push(kind_e k, logic [47:0] m, logic [31:0] ip, logic [7:0] t);
      arp_res_t r;
      if (step_q.size() >= 64) return;
      r.kind = k; r.mac = m; r.ip = ip; r.tag = t; r.fin = 0;
      step_q.push_back(r);
    endfunction

    function int lookup(logic [31:0] ip);
      for (int i = 0; i < 16; i++) if (used[i] && ent_ip[i] == ip) return i;
      return -1;
    endfunction

    function int vacant();
      for (int i = 0; i < 16; i++) if (!used[i]) return i;
      return -1;
    endfunction

    function void drop_entry(int s);
      used[s] = 0; resolved[s] = 0; pending[s] = 0; wcnt[s] = 0;
    endfunction

    function void store_mapping(logic [31:0] ip, logic [47:0] mac, bit upd);
      int s;
      s = lookup(ip);
      if (s >= 0) begin
        if (!upd) return;
      end else begin
        s = vacant();
        if (s < 0) return;
        used[s] = 1; ent_ip[s] = ip; pending[s] = 0; wcnt[s] = 0;
        retries[s] = 0; rtimer[s] = 0;
      end
      resolved[s] = 1;
      ent_mac[s] = mac;
      if (pending[s]) begin
        for (int k = 0; k < wcnt[s]; k++) push(RK_RELEASE, mac, ip, wtag[s][k]);
        pending[s] = 0; wcnt[s] = 0;
      end
      stamp[s] = now;
    endfunction

    function void park(int s, logic [31:0] ip, logic [7:0] t);
      if (wcnt[s] < 4) begin
        wtag[s][wcnt[s]] = t;
        wcnt[s]++;
        push(RK_QUEUED, '0, ip, t);
      end else push(RK_DROPPED, '0, ip, t);
    endfunction

    function void resolve(logic [31:0] ip, logic [7:0] t);
      int s;
      bit fresh;
      if (ip == my_ip) begin push(RK_FOUND, my_mac, ip, t); return; end
      if (ip == BCAST_IP) begin push(RK_FOUND, BCAST_MAC, ip, t); return; end
      if (ip == 0) begin push(RK_DROPPED, '0, ip, t); return; end
      s = lookup(ip);
      fresh = (s >= 0) && ((now - stamp[s]) < {16'd0, lifetime});
      if (fresh && resolved[s]) begin push(RK_FOUND, ent_mac[s], ip, t); return; end
      if (fresh && pending[s]) begin park(s, ip, t); return; end
      if (s < 0) begin
        s = vacant();
        if (s < 0) begin push(RK_DROPPED, '0, ip, t); return; end
        used[s] = 1; ent_ip[s] = ip; ent_mac[s] = 0; pending[s] = 0; wcnt[s] = 0;
      end
      if (!pending[s]) wcnt[s] = 0;
      resolved[s] = 0; pending[s] = 1; stamp[s] = now;
      retries[s] = 0; rtimer[s] = 0;
      park(s, ip, t);
      push(RK_REQUEST, '0, ip, 8'd0);
    endfunction

    function void tick();
      now = now + 32'd1;
      for (int s = 0; s < 16; s++) begin
        if (!used[s] || !pending[s]) continue;
        rtimer[s] = rtimer[s] + 16'd1;
        if (rtimer[s] < rq_timeout) continue;
        rtimer[s] = 0;
        retries[s] = retries[s] + 4'd1;
        if (retries[s] < retry_max) push(RK_REQUEST, '0, ent_ip[s], 8'd0);
        else begin
          for (int k = 0; k < wcnt[s]; k++) push(RK_UNREACH, '0, ent_ip[s], wtag[s][k]);
          drop_entry(s);
        end
      end
      sweep = sweep + 16'd1;
      if (sweep >= sweep_period) begin
        sweep = 0;
        for (int s = 0; s < 16; s++)
          if (used[s] && resolved[s] && ((now - stamp[s]) > {16'd0, lifetime}))
            drop_entry(s);
      end
    endfunction

    function void note_word(arp_word_t w);
      step_q.delete();
      n_words++;
      case (w.rtype)
        REQ_PACKET: begin
          if (w.hw == HW_ETHER && w.proto == PROTO_IPV4) begin
            if (w.op == OP_REQUEST) begin
              if (w.tip == my_ip) begin
                if (w.sip != 0) store_mapping(w.sip, w.smac, 1);
                push(RK_REPLY, w.smac, w.sip, 8'd0);
              end else if (w.sip != 0) store_mapping(w.sip, w.smac, 0);
            end else if (w.op == OP_REPLY && w.sip != 0) store_mapping(w.sip, w.smac, 1);
          end
        end
        REQ_RESOLVE: resolve(w.tip, w.ptag);
        REQ_TICK:    tick();
        default: ;
      endcase
      if (step_q.size() > 0) step_q[step_q.size()-1].fin = 1;
      foreach (step_q[i]) due_q.push_back(step_q[i]);
    endfunction

    function void check_result(logic [2:0] k, logic [47:0] m, logic [31:0] ip,
                               logic [7:0] t, logic l);
      arp_res_t e;
      n_results++;
      if (due_q.size() == 0) begin
        $error("unexpected result kind %0d ip %0h", k, ip);
        errors++;
        return;
      end
      e = due_q.pop_front();
      if (k !== e.kind) begin $error("result_kind: expected %0d, got %0d", e.kind, k); errors++; end
      if (m !== e.mac) begin $error("mac_addr: expected %0h, got %0h", e.mac, m); errors++; end
      if (ip !== e.ip) begin $error("ip_addr: expected %0h, got %0h", e.ip, ip); errors++; end
      if (t !== e.tag) begin $error("tag: expected %0h, got %0h", e.tag, t); errors++; end
      if (l !== e.fin) begin $error("last: expected %0d, got %0d", e.fin, l); errors++; end
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_ready_o;
  logic [1:0]  req_type_i;
  logic [15:0] hw_type_i, proto_type_i, opcode_i;
  logic [47:0] sender_mac_i;
  logic [31:0] sender_ip_i, target_ip_i;
  logic [7:0]  packet_tag_i;
  logic        out_valid_o, out_ready_i;
  logic [2:0]  result_kind_o;
  logic [47:0] mac_addr_o;
  logic [31:0] ip_addr_o;
  logic [7:0]  tag_o;
  logic        last_o;
  logic        cfg_valid_i, cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [47:0] cfg_data_i;

  arp_cache_resolver u_dut (.*);

  arp_scoreboard sb = new();
  int  burst_left = 0;
  bit  hold_req = 0;
  logic [31:0] own_ip_now = OWN_IP_RST;

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #20000000;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    arp_word_t w;
    if (rst_ni && in_valid_i && in_ready_o) begin
      w.rtype = req_type_i; w.hw = hw_type_i; w.proto = proto_type_i; w.op = opcode_i;
      w.smac = sender_mac_i; w.sip = sender_ip_i; w.tip = target_ip_i; w.ptag = packet_tag_i;
      sb.note_word(w);
    end
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(result_kind_o, mac_addr_o, ip_addr_o, tag_o, last_o);
  end

  // receiver: rotating stall mask with periodic random reseed, one long hold-off
  initial begin
    logic [15:0] mask;
    int cyc, hold;
    mask = '1; cyc = 0; hold = 0;
    out_ready_i = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin hold_req = 0; hold = 400; end
      if (cyc % 64 == 0) mask = ($urandom_range(0, 2) == 0) ? 16'hffff : 16'($urandom);
      cyc++;
      if (hold > 0) begin
        hold--;
        out_ready_i = 0;
      end else begin
        out_ready_i = mask[cyc % 16];
      end
    end
  end

  task automatic send(arp_word_t w);
    if (burst_left == 0) begin
      in_valid_i = 0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    req_type_i = w.rtype; hw_type_i = w.hw; proto_type_i = w.proto; opcode_i = w.op;
    sender_mac_i = w.smac; sender_ip_i = w.sip; target_ip_i = w.tip; packet_tag_i = w.ptag;
    in_valid_i = 1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    burst_left--;
  endtask

  task automatic settle();
    in_valid_i = 0;
    burst_left = 0;
    while (sb.due_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic cfg_write(cfg_e idx, logic [47:0] d);
    cfg_index_i = idx; cfg_data_i = d; cfg_valid_i = 1;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, d);
    if (idx == CFG_OWN_IP) own_ip_now = d[31:0];
    @(negedge clk_i);
    cfg_valid_i = 0;
  endtask

  function automatic arp_word_t mk(logic [1:0] rt, logic [15:0] op, logic [31:0] sip,
                                   logic [31:0] tip, logic [7:0] t);
    arp_word_t w;
    w.rtype = rt; w.hw = HW_ETHER; w.proto = PROTO_IPV4; w.op = op;
    w.smac = {16'($urandom), 32'($urandom)}; w.sip = sip; w.tip = tip; w.ptag = t;
    return w;
  endfunction

  function automatic logic [31:0] pick_ip();
    int r;
    r = $urandom_range(0, 99);
    if (r < 84) return 32'h0a00_0001 + $urandom_range(0, 23);
    if (r < 89) return own_ip_now;
    if (r < 92) return BCAST_IP;
    if (r < 95) return 32'd0;
    return $urandom;
  endfunction

  function automatic arp_word_t rand_word();
    arp_word_t w;
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) w = mk(REQ_RESOLVE, 16'($urandom), $urandom, pick_ip(), 8'($urandom));
    else if (r < 70) begin
      w = mk(REQ_PACKET, $urandom_range(0, 1) ? OP_REQUEST : OP_REPLY, pick_ip(),
             $urandom_range(0, 1) ? own_ip_now : pick_ip(), 8'($urandom));
    end else if (r < 90) w = mk(REQ_TICK, 16'($urandom), $urandom, $urandom, 8'($urandom));
    else begin
      w.rtype = 2'($urandom); w.hw = 16'($urandom); w.proto = 16'($urandom);
      w.op = 16'($urandom); w.smac = {16'($urandom), 32'($urandom)};
      w.sip = $urandom; w.tip = $urandom; w.ptag = 8'($urandom);
      if ($urandom_range(0, 1)) begin w.hw = HW_ETHER; w.proto = PROTO_IPV4; end
    end
    return w;
  endfunction

  initial begin
    arp_word_t w;
    logic [31:0] ipa, ipd;
    rst_ni = 0; in_valid_i = 0; cfg_valid_i = 0; cfg_index_i = CFG_OWN_IP; cfg_data_i = '0;
    req_type_i = REQ_TICK; hw_type_i = '0; proto_type_i = '0; opcode_i = '0;
    sender_mac_i = '0; sender_ip_i = '0; target_ip_i = '0; packet_tag_i = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    cfg_write(CFG_OWN_IP, 48'hc0a8_0001);
    cfg_write(CFG_OWN_MAC, 48'h0200_1234_5678);
    cfg_write(CFG_LIFETIME, 48'd5);
    cfg_write(CFG_REQ_TIMEOUT, 48'd3);
    cfg_write(CFG_MAX_RETRIES, 48'd2);
    cfg_write(CFG_STALE_PERIOD, 48'd4);

    // directed: self, broadcast, zero, queue fill and drop, reply release,
    // learning, bad headers, unknown kind, retry then unreachable, sweep
    ipa = 32'h0a00_0001; ipd = 32'h0a00_0002;
    send(mk(REQ_RESOLVE, 0, 0, own_ip_now, 8'h00));
    send(mk(REQ_RESOLVE, 0, 0, BCAST_IP, 8'hff));
    send(mk(REQ_RESOLVE, 0, 0, 32'd0, 8'h5a));
    for (int i = 0; i < 5; i++) send(mk(REQ_RESOLVE, 0, 0, ipa, 8'(8'h10 + i)));
    send(mk(REQ_PACKET, OP_REPLY, ipa, 32'h1234_5678, 0));
    send(mk(REQ_RESOLVE, 0, 0, ipa, 8'ha5));
    send(mk(REQ_PACKET, OP_REQUEST, 32'h0a00_0003, own_ip_now, 0));
    send(mk(REQ_PACKET, OP_REQUEST, 32'h0a00_0004, 32'h0a00_0009, 0));
    send(mk(REQ_PACKET, OP_REQUEST, 32'd0, own_ip_now, 0));
    w = mk(REQ_PACKET, OP_REQUEST, 32'h0a00_0005, own_ip_now, 0); w.hw = 16'hfffe; send(w);
    w = mk(REQ_PACKET, OP_REPLY, 32'h0a00_0005, 0, 0); w.proto = 16'h86dd; send(w);
    send(mk(REQ_PACKET, 16'hffff, 32'h0a00_0006, own_ip_now, 0));
    send(mk(2'd3, 0, 0, 0, 0));
    send(mk(REQ_RESOLVE, 0, 0, ipd, 8'h77));
    repeat (7) send(mk(REQ_TICK, 0, 0, 0, 0));
    settle();

    hold_req = 1;
    repeat (62) send(rand_word());
    settle();

    cfg_write(CFG_OWN_IP, 48'hffff_ffff);
    cfg_write(CFG_OWN_MAC, 48'hffff_ffff_ffff);
    cfg_write(CFG_LIFETIME, 48'd1);
    cfg_write(CFG_REQ_TIMEOUT, 48'd1);
    cfg_write(CFG_MAX_RETRIES, 48'd15);
    cfg_write(CFG_STALE_PERIOD, 48'd1);
    repeat (62) send(rand_word());
    settle();

    cfg_write(CFG_OWN_IP, 48'd0);
    cfg_write(CFG_OWN_MAC, 48'd0);
    cfg_write(CFG_LIFETIME, 48'hffff);
    cfg_write(CFG_REQ_TIMEOUT, 48'hffff);
    cfg_write(CFG_MAX_RETRIES, 48'd1);
    cfg_write(CFG_STALE_PERIOD, 48'hffff);
    repeat (62) send(rand_word());
    settle();

    $display("Covered %0d input words and %0d results over three register settings,",
             sb.n_words, sb.n_results);
    $display("including queue overflow, full table, retries and a long output hold-off.");
    if (sb.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/arpc_pkg.sv
rtl/arpc_ram.sv
rtl/arpc_out_buf.sv
rtl/arp_cache_resolver.sv
verif/arp_cache_resolver_tb.sv
